FILE: hw/rtl/event_and_ack_frame_parser_top_macros.svh
// Assertion helpers shared by the checker.
`ifndef EVENT_AND_ACK_FRAME_PARSER_TOP_MACROS_SVH
`define EVENT_AND_ACK_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define EAFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eafp check failed");

// Next-cycle implication, quiet during reset.
`define EAFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eafp check failed");

// Next-cycle implication that also covers reset itself.
`define EAFP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("eafp check failed");

`endif

FILE: hw/rtl/eafp_pkg.sv
`default_nettype none
package eafp_pkg;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_TYPE    = 4'd2,
    PH_LENHI   = 4'd3,
    PH_LENLO   = 4'd4,
    PH_HEAD    = 4'd5,
    PH_CLASSHI = 4'd6,
    PH_CLASSLO = 4'd7,
    PH_KINDHI  = 4'd8,
    PH_KINDLO  = 4'd9,
    PH_ID      = 4'd10,
    PH_DATA    = 4'd11,
    PH_CODE    = 4'd12,
    PH_DROP    = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    K_ID     = 3'd0,
    K_DATA   = 3'd1,
    K_EVENT  = 3'd2,
    K_ACK    = 3'd3,
    K_REJECT = 3'd4,
    K_TRUNC  = 3'd5
  } kind_t;

  localparam logic RegEventCode = 1'b0;
  localparam logic RegReplyCode = 1'b1;

  localparam logic [7:0]  EventCodeRst = 8'd1;
  localparam logic [7:0]  ReplyCodeRst = 8'd2;
  localparam logic [7:0]  SyncFirst    = 8'h55;
  localparam logic [7:0]  SyncSecond   = 8'haa;
  localparam logic [15:0] HdrLen       = 16'd21;
  localparam logic [15:0] ReplyLen     = 16'd1;
  localparam int          IdBytes      = 16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       segment_end;
    logic       expect_reply;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [8:0]  byte_index;
    logic [7:0]  frame_code;
    logic [7:0]  head_byte;
    logic [15:0] event_class;
    logic [15:0] event_kind;
    logic [9:0]  data_count;
    logic [7:0]  reply_code;
    logic        last_of_run;
  } out_t;

  // Up to two results produced by one byte.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } res_pair_t;

endpackage
`default_nettype wire

FILE: hw/rtl/event_and_ack_frame_parser_top.sv
// An accepted input beat is registered in the pend stage, and its results are then written to the result queue.
// Throughput: one byte per clock while the queue has room; a byte that ends a frame with two results
// (last id or data byte plus done, or a result plus truncation) takes two output beats.
// Results drain through a 4-entry queue; input stalls when fewer than two slots are free.
// Reset (rst, synchronous, active high) returns the parser to sync search, empties
// the queue and loads the frame type registers with 1 (event) and 2 (reply).
`default_nettype none
module event_and_ack_frame_parser_top #(
  parameter int MAX_DATA = 512
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire eafp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output eafp_pkg::out_t      out_data,
  input  wire logic           cfg_write,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  logic [7:0] event_code;
  logic [7:0] reply_code_cfg;

  logic            pend_valid;
  eafp_pkg::in_t   pend;
  logic            pend_go;

  eafp_pkg::res_pair_t res;

  eafp_pkg::out_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic [PtrW:0]   fill_next;
  logic [1:0]      push_n;
  logic            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_code     <= eafp_pkg::EventCodeRst;
      reply_code_cfg <= eafp_pkg::ReplyCodeRst;
    end else if (cfg_write) begin
      case (cfg_index)
        eafp_pkg::RegEventCode: event_code     <= cfg_data;
        eafp_pkg::RegReplyCode: reply_code_cfg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Process the held beat only when the queue can take two results.
  assign pend_go  = pend_valid && (fill <= (PtrW+1)'(Depth - 2));
  assign in_ready = !pend_valid || pend_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_ready) begin
      pend_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend <= in_data;
    end
  end

  eafp_parser #(
    .MAX_DATA(MAX_DATA)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .fire           (pend_go),
    .item           (pend),
    .event_code     (event_code),
    .reply_code_cfg (reply_code_cfg),
    .res            (res)
  );

  assign push_n    = pend_go ? res.count : 2'd0;
  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];
  assign fill_next = fill + (PtrW+1)'(push_n) - (PtrW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= res.first;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/eafp_parser.sv
`default_nettype none
module eafp_parser #(
  parameter int MAX_DATA = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire eafp_pkg::in_t     item,
  input  wire logic [7:0]        event_code,
  input  wire logic [7:0]        reply_code_cfg,
  output eafp_pkg::res_pair_t    res
);

  localparam int CntRaw = $clog2(MAX_DATA + 1);
  localparam int CntW   = (CntRaw > 5) ? CntRaw : 5;
  localparam logic [15:0] MaxLen = 16'(MAX_DATA + 21);

  eafp_pkg::phase_t phase, phase_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [15:0]      len, len_next;
  logic             mode, mode_next;
  logic [7:0]       hold, hold_next;
  logic [7:0]       head, head_next;
  logic [15:0]      cls, cls_next;
  logic [15:0]      knd, knd_next;
  logic [7:0]       code, code_next;
  logic [7:0]       ftype, ftype_next;

  logic             finished;
  logic [1:0]       n;
  eafp_pkg::kind_t  k0, k1;
  logic [7:0]       v0, v1;
  logic [8:0]       i0, i1;
  logic [15:0]      len_in;
  logic [15:0]      data_len;
  logic [16:0]      cnt_plus;
  logic [7:0]       rb;

  function automatic eafp_pkg::out_t mk_res(
    input eafp_pkg::kind_t k, input logic [7:0] v, input logic [8:0] idx,
    input logic [7:0] ft, input logic [7:0] hd, input logic [15:0] cl,
    input logic [15:0] kn, input logic [15:0] ln, input logic [7:0] cd,
    input logic last);
    eafp_pkg::out_t r;
    r = '0;
    r.kind        = k;
    r.byte_value  = v;
    r.byte_index  = idx;
    r.frame_code  = ft;
    r.last_of_run = last;
    if (k == eafp_pkg::K_EVENT) begin
      r.head_byte   = hd;
      r.event_class = cl;
      r.event_kind  = kn;
      r.data_count  = 10'(ln - eafp_pkg::HdrLen);
    end
    if (k == eafp_pkg::K_ACK) begin
      r.reply_code = cd;
    end
    return r;
  endfunction

  assign rb       = item.rx_byte;
  assign len_in   = {hold, rb};
  assign data_len = len - eafp_pkg::HdrLen;
  assign cnt_plus = 17'(cnt) + 17'd1;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    len_next   = len;
    mode_next  = mode;
    hold_next  = hold;
    head_next  = head;
    cls_next   = cls;
    knd_next   = knd;
    code_next  = code;
    ftype_next = ftype;
    finished   = 1'b0;
    n          = 2'd0;
    k0 = eafp_pkg::K_ID;
    k1 = eafp_pkg::K_ID;
    v0 = '0;
    v1 = '0;
    i0 = '0;
    i1 = '0;
    case (phase)
      eafp_pkg::PH_SYNC1: begin
        mode_next  = item.expect_reply;
        ftype_next = '0;
        hold_next  = rb;
        phase_next = eafp_pkg::PH_SYNC2;
      end
      eafp_pkg::PH_SYNC2: begin
        if (hold == eafp_pkg::SyncFirst && rb == eafp_pkg::SyncSecond) begin
          phase_next = eafp_pkg::PH_TYPE;
        end else begin
          k0 = eafp_pkg::K_REJECT;
          n = 2'd1;
          finished = 1'b1;
        end
      end
      eafp_pkg::PH_TYPE: begin
        ftype_next = rb;
        if (mode && rb != reply_code_cfg) begin
          k0 = eafp_pkg::K_REJECT;
          n = 2'd1;
          finished = 1'b1;
        end else begin
          phase_next = eafp_pkg::PH_LENHI;
        end
      end
      eafp_pkg::PH_LENHI: begin
        hold_next  = rb;
        phase_next = eafp_pkg::PH_LENLO;
      end
      eafp_pkg::PH_LENLO: begin
        len_next = len_in;
        if (mode) begin
          if (len_in != eafp_pkg::ReplyLen) begin
            k0 = eafp_pkg::K_REJECT;
            n = 2'd1;
            finished = 1'b1;
          end else begin
            phase_next = eafp_pkg::PH_CODE;
          end
        end else if (ftype != event_code || len_in < eafp_pkg::HdrLen ||
                     len_in > MaxLen) begin
          k0 = eafp_pkg::K_REJECT;
          n = 2'd1;
          finished = 1'b1;
        end else begin
          phase_next = eafp_pkg::PH_HEAD;
        end
      end
      eafp_pkg::PH_HEAD: begin
        head_next  = rb;
        phase_next = eafp_pkg::PH_CLASSHI;
      end
      eafp_pkg::PH_CLASSHI: begin
        hold_next  = rb;
        phase_next = eafp_pkg::PH_CLASSLO;
      end
      eafp_pkg::PH_CLASSLO: begin
        cls_next   = len_in;
        phase_next = eafp_pkg::PH_KINDHI;
      end
      eafp_pkg::PH_KINDHI: begin
        hold_next  = rb;
        phase_next = eafp_pkg::PH_KINDLO;
      end
      eafp_pkg::PH_KINDLO: begin
        knd_next   = len_in;
        cnt_next   = '0;
        phase_next = eafp_pkg::PH_ID;
      end
      eafp_pkg::PH_ID: begin
        k0 = eafp_pkg::K_ID;
        v0 = rb;
        i0 = 9'(cnt);
        n  = 2'd1;
        if (cnt == CntW'(eafp_pkg::IdBytes - 1)) begin
          cnt_next = '0;
          if (len == eafp_pkg::HdrLen) begin
            k1 = eafp_pkg::K_EVENT;
            n  = 2'd2;
            finished = 1'b1;
          end else begin
            phase_next = eafp_pkg::PH_DATA;
          end
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      eafp_pkg::PH_DATA: begin
        k0 = eafp_pkg::K_DATA;
        v0 = rb;
        i0 = 9'(cnt);
        n  = 2'd1;
        cnt_next = CntW'(cnt_plus);
        if (cnt_plus >= 17'(data_len)) begin
          k1 = eafp_pkg::K_EVENT;
          n  = 2'd2;
          finished = 1'b1;
        end
      end
      eafp_pkg::PH_CODE: begin
        code_next = rb;
        k0 = eafp_pkg::K_ACK;
        n  = 2'd1;
        finished = 1'b1;
      end
      default: begin
      end
    endcase

    if (finished) begin
      phase_next = eafp_pkg::PH_DROP;
    end
    // A segment closing mid-frame appends a truncation result.
    if (item.segment_end) begin
      if (phase_next != eafp_pkg::PH_DROP) begin
        if (n == 2'd0) begin
          k0 = eafp_pkg::K_TRUNC;
          n  = 2'd1;
        end else begin
          k1 = eafp_pkg::K_TRUNC;
          n  = 2'd2;
        end
      end
      phase_next = eafp_pkg::PH_SYNC1;
    end
  end

  always_comb begin
    res.count  = n;
    res.first  = mk_res(k0, v0, i0, ftype_next, head_next, cls_next, knd_next,
                        len_next, code_next, n == 2'd1);
    res.second = mk_res(k1, v1, i1, ftype_next, head_next, cls_next, knd_next,
                        len_next, code_next, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= eafp_pkg::PH_SYNC1;
      cnt   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      len   <= len_next;
      mode  <= mode_next;
      hold  <= hold_next;
      head  <= head_next;
      cls   <= cls_next;
      knd   <= knd_next;
      code  <= code_next;
      ftype <= ftype_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/eafp_checker.sv
`default_nettype none
`include "event_and_ack_frame_parser_top_macros.svh"
module eafp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire eafp_pkg::out_t out_data
);

  logic byte_kind;
  logic event_kind_done;

  assign byte_kind = (out_data.kind == eafp_pkg::K_ID) ||
                     (out_data.kind == eafp_pkg::K_DATA);
  assign event_kind_done = (out_data.kind == eafp_pkg::K_EVENT);

  // A stalled result beat holds.
  `EAFP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data))

  // Only id and data beats carry a byte.
  `EAFP_ASSERT_NOW(a_byte_zero, clk, rst, out_valid && !byte_kind,
    out_data.byte_value == 8'd0 && out_data.byte_index == 9'd0)

  // Event fields appear only with event done.
  `EAFP_ASSERT_NOW(a_event_zero, clk, rst, out_valid && !event_kind_done,
    out_data.head_byte == 8'd0 && out_data.event_class == 16'd0 &&
    out_data.event_kind == 16'd0 && out_data.data_count == 10'd0)

  // Reset drops any queued result.
  `EAFP_ASSERT_ALWAYS(a_rst_empty, clk, rst, !out_valid)

endmodule

bind event_and_ack_frame_parser_top eafp_checker u_eafp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
